/* sv/stmp_pkg.sv */
// Shared types and constants for the styled text markup parser.
// Used by stmp_ctrl, stmp_dp and styled_text_markup_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stmp_pkg;

   localparam int COLOR_STACK_DEPTH_DEF = 8;
   localparam int LOOKAHEAD_DEPTH_DEF   = 16;
   // tag scan window: '<', up to 14 tag bytes, '>'
   localparam int WINDOW                = 16;

   localparam logic [1:0] RK_CHAR      = 2'd0;
   localparam logic [1:0] RK_RUN_END   = 2'd1;
   localparam logic [1:0] RK_LINE_END  = 2'd2;
   localparam logic [1:0] RK_FINAL_END = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] out_byte;
      logic       bold;
      logic       color_valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       stack_overflow;
      logic       last_of_item;
   } rsp_type;

   typedef enum logic [2:0] {
      ACT_WAIT,
      ACT_RUN_END,
      ACT_LITERAL,
      ACT_TAG,
      ACT_FINAL
   } act_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic fin_mode;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    emits;
      logic    hold;
      logic    pnd_valid;
      logic    out_free;
   } stat_type;

endpackage

`default_nettype wire

/* sv/stmp_ctrl.sv */
// Sequencer for the markup parser: accepts requests and steps the datapath.
// Depends on stmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stmp_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_kind,
   output logic              req_stall,
   input  stmp_pkg::stat_type stat,
   output stmp_pkg::cmd_type  cmd
);
   import stmp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROC,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      room;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      // a result may be produced when the pending slot can be emptied
      room     = !stat.pnd_valid || stat.out_free;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = !req_kind;
               state_in = req_kind ? ST_FIN : ST_PROC;
            end
         end
         ST_PROC, ST_FIN: begin
            cmd.fin_mode = (state_ff == ST_FIN);
            if (stat.act == ACT_WAIT) begin
               if (room) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if ((!stat.emits || room) && !stat.hold) begin
               cmd.step = 1'b1;
               if (stat.act == ACT_FINAL) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (room) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* sv/stmp_dp.sv */
// Datapath of the markup parser: lookahead buffer, tag and entity decode,
// style state, color stack memory and the pending/output result registers.
// Depends on stmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stmp_dp #(
   parameter int COLOR_STACK_DEPTH = stmp_pkg::COLOR_STACK_DEPTH_DEF,
   parameter int LOOKAHEAD_DEPTH   = stmp_pkg::LOOKAHEAD_DEPTH_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  stmp_pkg::req_type  req_data,
   input  stmp_pkg::cmd_type  cmd,
   output stmp_pkg::stat_type stat,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output stmp_pkg::rsp_type  rsp_data
);
   import stmp_pkg::*;

   localparam int LCW = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int LIW = $clog2(LOOKAHEAD_DEPTH);
   localparam int CDW = $clog2(COLOR_STACK_DEPTH + 1);
   localparam int CIW = (COLOR_STACK_DEPTH > 1) ? $clog2(COLOR_STACK_DEPTH) : 1;
   localparam int CLW = $clog2(WINDOW);
   localparam int CNW = $clog2(WINDOW + 1);

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [7:0] TAG_COLOR [6] = '{"c", "o", "l", "o", "r", "="};
   localparam logic [7:0] ENT_LT    [4] = '{"&", "l", "t", ";"};
   localparam logic [7:0] ENT_GT    [4] = '{"&", "g", "t", ";"};
   localparam logic [7:0] ENT_AMP   [5] = '{"&", "a", "m", "p", ";"};

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      v = '0;
      if (c >= "0" && c <= "9") begin
         v = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         v = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         v = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return v;
   endfunction

   // lookahead buffer and style state
   logic [7:0]     la_ff [LOOKAHEAD_DEPTH];
   logic [7:0]     la_shift [LOOKAHEAD_DEPTH];
   logic [LCW-1:0] la_cnt_ff;
   logic [31:0]    cs_mem [COLOR_STACK_DEPTH];
   logic [31:0]    cs_rd_ff;
   logic [31:0]    cs_top_ff;
   logic [CDW-1:0] cs_depth_ff;
   logic [CDW-1:0] cs_depth_prev_ff;
   logic [CDW-1:0] cs_rd_full;
   logic [7:0]     excess_ff;
   logic [7:0]     bold_ff;
   logic           run_open_ff;
   logic           ovf_ff;

   // result registers
   rsp_type pnd_ff;
   rsp_type pnd_last;
   logic    pnd_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // decode
   logic           has_close;
   logic [CLW-1:0] close;
   logic [4:0]     hv [8];
   logic           color_pre, hex6_ok, hex8_ok;
   logic           is_br, is_b, is_eb, is_ecolor, is_col6, is_col8, rec;
   logic [31:0]    col_val;
   logic           m_lt, m_gt, m_amp, full_any, maybe;
   logic [7:0]     ent_byte;
   logic [2:0]     ent_n;
   act_type        act;
   logic [7:0]     lit_byte;
   logic [2:0]     lit_n;
   logic [CNW-1:0] cons_n;
   logic           emits;
   logic           is_pop;
   logic           hold;
   logic           out_free;
   logic           push_we;
   rsp_type        new_res;
   int             ix;

   // tag close search over the fixed window
   always_comb begin
      has_close = 1'b0;
      close     = '0;
      for (int k = WINDOW - 1; k >= 1; k--) begin
         if (LCW'(k) < la_cnt_ff && la_ff[k] == CH_GT) begin
            has_close = 1'b1;
            close     = CLW'(k);
         end
      end
   end

   always_comb begin
      color_pre = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (la_ff[1 + i] != TAG_COLOR[i]) color_pre = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
         hv[i] = hex_val(la_ff[7 + i]);
      end
      hex6_ok = hv[0][4] & hv[1][4] & hv[2][4] & hv[3][4] & hv[4][4] & hv[5][4];
      hex8_ok = hex6_ok & hv[6][4] & hv[7][4];
      is_b  = has_close && close == CLW'(2) && la_ff[1] == "b";
      is_br = has_close && close == CLW'(3) && la_ff[1] == "b" && la_ff[2] == "r";
      is_eb = has_close && close == CLW'(3) && la_ff[1] == CH_SLASH && la_ff[2] == "b";
      is_ecolor = has_close && close == CLW'(7) && la_ff[1] == CH_SLASH
                  && la_ff[2] == "c" && la_ff[3] == "o" && la_ff[4] == "l"
                  && la_ff[5] == "o" && la_ff[6] == "r";
      is_col6 = has_close && close == CLW'(13) && color_pre && hex6_ok;
      is_col8 = has_close && close == CLW'(15) && color_pre && hex8_ok;
      rec     = is_b || is_br || is_eb || is_ecolor || is_col6 || is_col8;
      if (is_col8) begin
         col_val = {hv[0][3:0], hv[1][3:0], hv[2][3:0], hv[3][3:0],
                    hv[4][3:0], hv[5][3:0], hv[6][3:0], hv[7][3:0]};
      end else begin
         col_val = {hv[0][3:0], hv[1][3:0], hv[2][3:0], hv[3][3:0],
                    hv[4][3:0], hv[5][3:0], 8'hFF};
      end
   end

   // entity prefix match, bytes not yet held count as matching
   always_comb begin
      m_lt  = 1'b1;
      m_gt  = 1'b1;
      m_amp = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (LCW'(i) < la_cnt_ff && la_ff[i] != ENT_LT[i]) m_lt = 1'b0;
         if (LCW'(i) < la_cnt_ff && la_ff[i] != ENT_GT[i]) m_gt = 1'b0;
      end
      for (int i = 0; i < 5; i++) begin
         if (LCW'(i) < la_cnt_ff && la_ff[i] != ENT_AMP[i]) m_amp = 1'b0;
      end
      full_any = 1'b1;
      ent_byte = CH_AMP;
      ent_n    = 3'd5;
      if (m_lt && la_cnt_ff >= LCW'(4)) begin
         ent_byte = CH_LT;
         ent_n    = 3'd4;
      end else if (m_gt && la_cnt_ff >= LCW'(4)) begin
         ent_byte = CH_GT;
         ent_n    = 3'd4;
      end else if (!(m_amp && la_cnt_ff >= LCW'(5))) begin
         full_any = 1'b0;
      end
      maybe = (m_lt && la_cnt_ff < LCW'(4)) || (m_gt && la_cnt_ff < LCW'(4))
              || (m_amp && la_cnt_ff < LCW'(5));
   end

   // next action on the head of the buffer
   always_comb begin
      act      = ACT_LITERAL;
      lit_byte = la_ff[0];
      lit_n    = 3'd1;
      if (la_cnt_ff == '0) begin
         if (!cmd.fin_mode) begin
            act = ACT_WAIT;
         end else if (run_open_ff) begin
            act = ACT_RUN_END;
         end else begin
            act = ACT_FINAL;
         end
      end else if (la_ff[0] == CH_LT) begin
         if (rec) begin
            act = run_open_ff ? ACT_RUN_END : ACT_TAG;
         end else if (!has_close && !cmd.fin_mode && la_cnt_ff < LCW'(WINDOW)) begin
            act = ACT_WAIT;
         end
      end else if (la_ff[0] == CH_AMP) begin
         if (full_any) begin
            lit_byte = ent_byte;
            lit_n    = ent_n;
         end else if (maybe && !cmd.fin_mode) begin
            act = ACT_WAIT;
         end
      end
      cons_n = (act == ACT_TAG) ? CNW'(close) + CNW'(1) : CNW'(lit_n);
      emits  = (act == ACT_RUN_END) || (act == ACT_LITERAL) || (act == ACT_FINAL)
               || (act == ACT_TAG && is_br);
   end

   assign is_pop  = (act == ACT_TAG) && is_ecolor && excess_ff == '0 && cs_depth_ff != '0;
   // the stack read port must settle after a depth change before a pop
   assign hold    = is_pop && (cs_depth_ff != cs_depth_prev_ff);
   assign push_we = cmd.step && (act == ACT_TAG) && (is_col6 || is_col8)
                    && cs_depth_ff < CDW'(COLOR_STACK_DEPTH);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cs_rd_full = cs_depth_ff - CDW'(2);

   always_comb begin
      for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
         ix = i + int'(cons_n);
         if (ix < LOOKAHEAD_DEPTH) begin
            la_shift[i] = la_ff[LIW'(ix)];
         end else begin
            la_shift[i] = la_ff[i];
         end
      end
   end

   always_comb begin
      new_res                = '0;
      new_res.bold           = (bold_ff != '0);
      new_res.color_valid    = (cs_depth_ff != '0);
      new_res.stack_overflow = ovf_ff;
      if (cs_depth_ff != '0) begin
         {new_res.red, new_res.green, new_res.blue, new_res.alpha} = cs_top_ff;
      end
      case (act)
         ACT_LITERAL: begin
            new_res.result_kind = RK_CHAR;
            new_res.out_byte    = lit_byte;
         end
         ACT_RUN_END: new_res.result_kind = RK_RUN_END;
         ACT_TAG:     new_res.result_kind = RK_LINE_END;
         ACT_FINAL:   new_res.result_kind = RK_FINAL_END;
         default:     new_res.result_kind = RK_CHAR;
      endcase
   end

   // last result of a request carries the end marker
   always_comb begin
      pnd_last              = pnd_ff;
      pnd_last.last_of_item = 1'b1;
   end

   // buffer payload, color stack memory and the result data registers
   always_ff @(posedge clock) begin
      if (cmd.load && la_cnt_ff < LCW'(LOOKAHEAD_DEPTH)) begin
         la_ff[la_cnt_ff[LIW-1:0]] <= req_data.text_byte;
      end else if (cmd.step && (act == ACT_LITERAL || act == ACT_TAG)) begin
         la_ff <= la_shift;
      end
      if (push_we) begin
         cs_mem[cs_depth_ff[CIW-1:0]] <= col_val;
      end
      cs_rd_ff <= cs_mem[cs_rd_full[CIW-1:0]];
      if (push_we) begin
         cs_top_ff <= col_val;
      end else if (cmd.step && is_pop) begin
         cs_top_ff <= cs_rd_ff;
      end
      if (cmd.finish && pnd_valid_ff) begin
         rsp_ff <= pnd_last;
      end else if (cmd.step && emits && pnd_valid_ff) begin
         rsp_ff <= pnd_ff;
      end
      if (cmd.step && emits) begin
         pnd_ff <= new_res;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         la_cnt_ff        <= '0;
         cs_depth_ff      <= '0;
         cs_depth_prev_ff <= '0;
         excess_ff        <= '0;
         bold_ff          <= '0;
         run_open_ff      <= 1'b0;
         ovf_ff           <= 1'b0;
         pnd_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cs_depth_prev_ff <= cs_depth_ff;
         if (cmd.load && la_cnt_ff < LCW'(LOOKAHEAD_DEPTH)) begin
            la_cnt_ff <= la_cnt_ff + LCW'(1);
         end
         if (cmd.step) begin
            case (act)
               ACT_RUN_END: run_open_ff <= 1'b0;
               ACT_LITERAL: begin
                  run_open_ff <= 1'b1;
                  la_cnt_ff   <= la_cnt_ff - LCW'(cons_n);
               end
               ACT_TAG: begin
                  la_cnt_ff <= la_cnt_ff - LCW'(cons_n);
                  if (is_b && bold_ff != 8'hFF) begin
                     bold_ff <= bold_ff + 8'd1;
                  end
                  if (is_eb && bold_ff != '0) begin
                     bold_ff <= bold_ff - 8'd1;
                  end
                  if (is_col6 || is_col8) begin
                     if (push_we) begin
                        cs_depth_ff <= cs_depth_ff + CDW'(1);
                     end else begin
                        ovf_ff <= 1'b1;
                        if (excess_ff != 8'hFF) excess_ff <= excess_ff + 8'd1;
                     end
                  end
                  if (is_ecolor) begin
                     if (excess_ff != '0) begin
                        excess_ff <= excess_ff - 8'd1;
                     end else if (cs_depth_ff != '0) begin
                        cs_depth_ff <= cs_depth_ff - CDW'(1);
                     end
                  end
               end
               ACT_FINAL: begin
                  la_cnt_ff   <= '0;
                  cs_depth_ff <= '0;
                  excess_ff   <= '0;
                  bold_ff     <= '0;
                  run_open_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.finish) begin
            pnd_valid_ff <= 1'b0;
         end else if (cmd.step && emits) begin
            pnd_valid_ff <= 1'b1;
         end
         if (cmd.finish && pnd_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (cmd.step && emits && pnd_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat           = '0;
      stat.act       = act;
      stat.emits     = emits;
      stat.hold      = hold;
      stat.pnd_valid = pnd_valid_ff;
      stat.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_la_bound: assert property (@(posedge clock) disable iff (reset)
      la_cnt_ff <= LCW'(WINDOW))
      else $error("lookahead count above scan window");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cs_depth_ff <= CDW'(COLOR_STACK_DEPTH))
      else $error("color depth above stack size");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && emits && pnd_valid_ff) |-> out_free)
      else $error("pending result moved into a busy output");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !pnd_valid_ff)
      else $error("pending result left after finish");
`endif

endmodule

`default_nettype wire

/* sv/styled_text_markup_parser.sv */
// Sequence: a text byte is accepted, then each result or tag action takes a step
// when it can go on, then a close; no new request is taken until that close.
// A /color right after a depth change waits for the stack read port to settle.
// End of text: accept, a step for each literal, tag action, run end and final
// line end, then close. Reset is synchronous and clears control state only;
// buffer and stack contents need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module styled_text_markup_parser #(
   parameter int COLOR_STACK_DEPTH = stmp_pkg::COLOR_STACK_DEPTH_DEF,
   parameter int LOOKAHEAD_DEPTH   = stmp_pkg::LOOKAHEAD_DEPTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  stmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output stmp_pkg::rsp_type rsp_data
);
   import stmp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   stmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   stmp_dp #(
      .COLOR_STACK_DEPTH (COLOR_STACK_DEPTH),
      .LOOKAHEAD_DEPTH   (LOOKAHEAD_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* test/styled_text_markup_parser_tb.sv */
// Testbench for styled_text_markup_parser: drives text bytes and end-of-text
// requests, predicts styled characters, run ends and line ends, checks them.
// Depends on stmp_pkg and the styled_text_markup_parser RTL.
`timescale 1ns / 1ps

module styled_text_markup_parser_tb;
   import stmp_pkg::*;

   localparam int STACK_DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   styled_text_markup_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   byte unsigned held_bytes[$];
   logic [31:0]  colors[STACK_DEPTH];
   int           color_depth, excess_pushes, bold_level;
   bit           run_open, overflow_seen;
   rsp_type      step_results[$];
   rsp_type      expected_results[$];

   req_type pending_requests[$];
   int      errors = 0, n_requests = 0, n_results = 0;
   bit      sender_idle_enable = 1, receiver_idle_enable = 1;
   bit      long_hold_request = 0;
   bit      drain_pause = 0;
   int      idle_cycles = 0;

   function automatic void emit_result(logic [1:0] kind, logic [7:0] ch);
      rsp_type r;
      r = '0;
      if (step_results.size() >= 32) return;
      r.result_kind    = kind;
      r.out_byte       = ch;
      r.bold           = bold_level > 0;
      r.color_valid    = color_depth > 0;
      if (color_depth > 0)
         {r.red, r.green, r.blue, r.alpha} = colors[color_depth - 1];
      r.stack_overflow = overflow_seen;
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic void close_run();
      if (run_open) begin
         emit_result(RK_RUN_END, 8'd0);
         run_open = 0;
      end
   endfunction

   function automatic void drop_held(int n);
      for (int i = 0; i < n && held_bytes.size() > 0; i++) void'(held_bytes.pop_front());
   endfunction

   function automatic void put_literal(byte unsigned ch, int n);
      emit_result(RK_CHAR, ch);
      run_open = 1;
      drop_held(n);
   endfunction

   function automatic int hex_digit(byte unsigned c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // tag body lies in held_bytes[1 .. len]
   function automatic bit apply_tag(int len);
      string tag_text;
      int    digits, h;
      logic [31:0] value;
      tag_text = "";
      for (int i = 1; i <= len; i++) tag_text = {tag_text, string'(held_bytes[i])};
      if (tag_text == "br") begin
         close_run();
         emit_result(RK_LINE_END, 8'd0);
         return 1;
      end
      if (tag_text == "b") begin
         close_run();
         if (bold_level < 255) bold_level++;
         return 1;
      end
      if (tag_text == "/b") begin
         close_run();
         if (bold_level > 0) bold_level--;
         return 1;
      end
      if (len >= 6 && tag_text.substr(0, 5) == "color=") begin
         digits = len - 6;
         value = '0;
         if (digits != 6 && digits != 8) return 0;
         for (int i = 0; i < digits; i++) begin
            h = hex_digit(held_bytes[7 + i]);
            if (h < 0) return 0;
            value = {value[27:0], 4'(h)};
         end
         if (digits == 6) value = {value[23:0], 8'hFF};
         close_run();
         if (color_depth < STACK_DEPTH) begin
            colors[color_depth] = value;
            color_depth++;
         end else begin
            if (excess_pushes < 255) excess_pushes++;
            overflow_seen = 1;
         end
         return 1;
      end
      if (tag_text == "/color") begin
         close_run();
         if (excess_pushes > 0) excess_pushes--;
         else if (color_depth > 0) color_depth--;
         return 1;
      end
      return 0;
   endfunction

   function automatic bit entity_match(string ent, int m);
      for (int i = 0; i < m; i++)
         if (held_bytes[i] != ent[i]) return 0;
      return 1;
   endfunction

   function automatic void scan_held(bit at_end);
      string ents[3] = '{"&lt;", "&gt;", "&amp;"};
      byte unsigned vals[3] = '{"<", ">", "&"};
      byte unsigned head;
      int lim, close_at, m;
      bit done, maybe;
      while (held_bytes.size() > 0 && step_results.size() < 32) begin
         head = held_bytes[0];
         if (head == "<") begin
            lim = held_bytes.size() < WINDOW ? held_bytes.size() : WINDOW;
            close_at = 0;
            for (int k = 1; k < lim; k++)
               if (held_bytes[k] == ">") begin
                  close_at = k;
                  break;
               end
            if (close_at > 0) begin
               if (apply_tag(close_at - 1)) begin
                  drop_held(close_at + 1);
                  continue;
               end
            end else if (!at_end && held_bytes.size() < WINDOW) begin
               return;
            end
            put_literal(head, 1);
         end else if (head == "&") begin
            done = 0;
            maybe = 0;
            for (int e = 0; e < 3 && !done; e++) begin
               m = held_bytes.size() < ents[e].len() ? held_bytes.size() : ents[e].len();
               if (entity_match(ents[e], m)) begin
                  if (m == ents[e].len()) begin
                     put_literal(vals[e], m);
                     done = 1;
                  end else maybe = 1;
               end
            end
            if (done) continue;
            if (maybe && !at_end) return;
            put_literal(head, 1);
         end else begin
            put_literal(head, 1);
         end
      end
   endfunction

   function automatic void predict_request(req_type rq);
      step_results.delete();
      if (!rq.kind) begin
         if (held_bytes.size() < 16) held_bytes.insert(held_bytes.size(), rq.text_byte);
         scan_held(0);
      end else begin
         scan_held(1);
         close_run();
         emit_result(RK_FINAL_END, 8'd0);
         held_bytes.delete();
         color_depth = 0;
         excess_pushes = 0;
         bold_level = 0;
         run_open = 0;
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_item = 1;
      foreach (step_results[i])
         expected_results.insert(expected_results.size(), step_results[i]);
   endfunction

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      errors++;
      $display("mismatch #%0d (%s): got %h want %h", errors, what, got, want);
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_data);
            n_requests++;
            void'(pending_requests.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold payload
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (drain_pause && (expected_results.size() > 0 ||
                                      (req_valid && !req_stall))) begin
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests[0];
            if (sender_idle_enable && $urandom_range(0, 15) == 0)
               send_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected", rsp_data, '0);
            end else begin
               if (rsp_data !== expected_results[0])
                  report_mismatch("field", rsp_data, expected_results[0]);
               void'(expected_results.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (long_hold_request) begin
            long_hold_request <= 0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle_enable && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_byte(byte unsigned b);
      req_type rq;
      rq.kind = 1'b0;
      rq.text_byte = b;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   task automatic queue_end();
      req_type rq;
      rq.kind = 1'b1;
      rq.text_byte = 8'($urandom_range(0, 255));
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic wait_queue_empty();
      while (pending_requests.size() > 0) @(posedge clock);
   endtask

   function automatic string random_hex(int n);
      string s, digits;
      digits = "0123456789abcdefABCDEF";
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(0, 21)])};
      return s;
   endfunction

   function automatic string random_piece();
      string p;
      case ($urandom_range(0, 15))
         0:  p = "<b>";
         1:  p = "</b>";
         2:  p = "<br>";
         3:  p = {"<color=", random_hex(6), ">"};
         4:  p = {"<color=", random_hex(8), ">"};
         5:  p = "</color>";
         6:  p = "&lt;";
         7:  p = "&gt;";
         8:  p = "&amp;";
         9:  p = {"<color=", random_hex($urandom_range(0, 9)), ">"};
         10: p = "&a";
         11: p = "<";
         12: p = ">";
         13: p = {"&", random_hex(2)};
         default: begin
            p = "";
            for (int i = 0; i < $urandom_range(1, 4); i++)
               p = {p, string'(byte'($urandom_range(0, 255)))};
         end
      endcase
      return p;
   endfunction

   initial begin
      string s;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: tags, entities, nesting, odd cases
      queue_text("<color=1A2b3C>c<color=DEADBEEF>d</color></b><zz>");
      queue_end();
      queue_text("<012345678901234>&am");
      queue_end();
      queue_text("<b");
      queue_end();
      // overflow of the color stack
      for (int i = 0; i < 9; i++) queue_text({"<color=", random_hex(6), ">"});
      queue_text("x</color></color>y");
      queue_end();
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h80);
      queue_byte(8'h7F);
      queue_end();
      wait_queue_empty();

      // sender pause until drained
      drain_pause = 1;
      queue_text("q");
      wait_queue_empty();
      while (expected_results.size() > 0) @(posedge clock);
      drain_pause = 0;

      // long receiver hold while text keeps coming
      long_hold_request = 1;
      queue_text("&lt;<b>B</b><br>&x");
      wait_queue_empty();

      // random, mostly well-formed, no idling
      sender_idle_enable = 0;
      receiver_idle_enable = 0;
      while (n_requests < 255) begin
         s = "";
         for (int i = 0; i < $urandom_range(1, 6); i++) s = {s, random_piece()};
         queue_text(s);
         if ($urandom_range(0, 3) == 0) queue_end();
         wait_queue_empty();
      end
      queue_end();
      wait_queue_empty();
      while (expected_results.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (expected_results.size() > 0) errors++;
      $display("covered %0d requests and %0d results: tags, entities, nesting, overflow,",
               n_requests, n_results);
      $display("unrecognized markup, long stalls and idle gaps");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
